>>> rtl/mcm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the matrix chain multiplier.
// Used by the front end, the item queue and the back end.
package mcm_pkg;

    localparam int unsigned ELEM_W    = 64;
    localparam int unsigned SIZE_W    = 4;   // matrix_size register width
    localparam int unsigned LEN_W     = 8;   // chain_length register width
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 8;
    localparam int unsigned POS_W     = 6;   // element index for the largest supported size

    localparam logic [CFG_IDX_W-1:0] REG_MATRIX_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHAIN_LENGTH = 2'd1;

    // One classified element travelling from the front end to the back end.
    typedef struct packed {
        logic [ELEM_W-1:0] element;
        logic [POS_W-1:0]  pos;
        logic              first;  // belongs to the first matrix of the chain
        logic              eom;    // last element of its matrix
        logic              eoc;    // last element of the chain
    } t_item;

endpackage

>>> rtl/mcm_front.sv
`timescale 1ns / 1ps
// Front end: configuration registers, element and matrix position tracking.
// Depends on mcm_pkg; feeds classified items into mcm_queue.
module mcm_front
    import mcm_pkg::*;
#(
    parameter int unsigned MAX_SIZE = 8,
    parameter int unsigned SZ_W     = 4,
    parameter int unsigned ADDR_W   = 6,
    parameter int unsigned CELL_W   = 7
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    input  logic                 push,
    input  logic [ELEM_W-1:0]    i_element,
    input  logic                 i_q_full,
    output logic                 o_q_push,
    output t_item                o_q_item,
    output logic [SZ_W-1:0]      o_size,
    output logic [CELL_W-1:0]    o_cells
);

    logic [SIZE_W-1:0] r_size;
    logic [LEN_W-1:0]  r_len;
    logic [ADDR_W-1:0] r_epos;
    logic [LEN_W-1:0]  r_mpos;
    logic [SIZE_W-1:0] size_eff;
    logic [LEN_W:0]    len_eff;
    logic              eom;
    logic              eoc;

    always_comb begin
        if (r_size == '0) begin
            size_eff = SIZE_W'(1);
        end else if (r_size > SIZE_W'(MAX_SIZE)) begin
            size_eff = SIZE_W'(MAX_SIZE);
        end else begin
            size_eff = r_size;
        end
        o_size   = SZ_W'(size_eff);
        o_cells  = CELL_W'(o_size) * CELL_W'(o_size);
        len_eff  = (r_len == '0) ? (LEN_W+1)'(1) : {1'b0, r_len};
        eom      = (({1'b0, r_epos} + CELL_W'(1)) == o_cells);
        eoc      = eom && (({1'b0, r_mpos} + (LEN_W+1)'(1)) == len_eff);
        o_q_push = push && !i_q_full;
        o_q_item.element = i_element;
        o_q_item.pos     = POS_W'(r_epos);
        o_q_item.first   = (r_mpos == '0);
        o_q_item.eom     = eom;
        o_q_item.eoc     = eoc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= SIZE_W'(8);
            r_len  <= LEN_W'(2);
            r_epos <= '0;
            r_mpos <= '0;
        end else if (i_cfg_we &&
                     (i_cfg_index == REG_MATRIX_SIZE || i_cfg_index == REG_CHAIN_LENGTH)) begin
            if (i_cfg_index == REG_MATRIX_SIZE) begin
                r_size <= i_cfg_data[SIZE_W-1:0];
            end else begin
                r_len <= i_cfg_data[LEN_W-1:0];
            end
            r_epos <= '0;
            r_mpos <= '0;
        end else if (o_q_push) begin
            if (eom) begin
                r_epos <= '0;
                r_mpos <= eoc ? '0 : r_mpos + LEN_W'(1);
            end else begin
                r_epos <= r_epos + ADDR_W'(1);
            end
        end
    end

endmodule

>>> rtl/mcm_queue.sv
`timescale 1ns / 1ps
// Four-entry queue of classified items between the front and back ends.
// Depends on mcm_pkg for the item type.
module mcm_queue
    import mcm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_item o_item
);

    localparam int unsigned DEPTH = 4;
    localparam int unsigned PTR_W = 2;

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [PTR_W:0]   r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == (PTR_W+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + (PTR_W+1)'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - (PTR_W+1)'(1);
            end
        end
    end

endmodule

>>> rtl/mcm_back.sv
`timescale 1ns / 1ps
// Back end: matrix stores, pipelined multiply-accumulate sequencer and result register.
// Depends on mcm_pkg; takes items from mcm_queue.
module mcm_back
    import mcm_pkg::*;
#(
    parameter int unsigned SZ_W   = 4,
    parameter int unsigned ADDR_W = 6,
    parameter int unsigned CELL_W = 7
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [SZ_W-1:0]   i_size,
    input  logic [CELL_W-1:0] i_cells,
    input  logic              i_q_empty,
    input  t_item             i_q_item,
    output logic              o_q_pop,
    output logic              empty,
    input  logic              pop,
    output logic [ELEM_W-1:0] o_product_element,
    output logic              o_last_element
);

    localparam int unsigned MDEPTH = 1 << ADDR_W;
    localparam int unsigned HALF_W = ELEM_W / 2;

    typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DRAIN, ST_OUT} t_state;

    typedef struct packed {
        logic              valid;
        logic              first;
        logic              last;
        logic [ADDR_W-1:0] dest;
    } t_tag;

    // Product store holds two banks: the current product and the one being built.
    logic [ELEM_W-1:0] r_pmem [2*MDEPTH];
    logic [ELEM_W-1:0] r_mmem [MDEPTH];

    t_state            r_state;
    logic              r_bank;
    logic              r_eoc;
    logic [SZ_W-1:0]   r_i;
    logic [SZ_W-1:0]   r_j;
    logic [SZ_W-1:0]   r_k;
    logic [CELL_W-1:0] r_oidx;
    logic              r_out_valid;
    logic              r_out_last;
    logic [ELEM_W-1:0] r_out_data;

    t_tag              r_s1;
    t_tag              r_s2;
    t_tag              r_s3;
    logic [ELEM_W-1:0] r_pdata;
    logic [ELEM_W-1:0] r_mdata;
    logic [ELEM_W-1:0] r_pp0;
    logic [HALF_W-1:0] r_pp1;
    logic [HALF_W-1:0] r_pp2;
    logic [ELEM_W-1:0] r_prod;
    logic [ELEM_W-1:0] r_acc;
    logic [ELEM_W-1:0] n_acc;

    logic [2*SZ_W-1:0] ik;
    logic [2*SZ_W-1:0] kj;
    logic [2*SZ_W-1:0] ij;
    logic              mac_issue;
    logic              out_issue;
    logic              mac_done;
    logic              mac_wr;
    logic              k_last;
    logic              j_last;
    logic              i_last;
    logic [ADDR_W:0]   p_rd_addr;
    logic [ADDR_W-1:0] q_pos;

    always_comb begin
        ik        = {{SZ_W{1'b0}}, r_i} * {{SZ_W{1'b0}}, i_size} + {{SZ_W{1'b0}}, r_k};
        kj        = {{SZ_W{1'b0}}, r_k} * {{SZ_W{1'b0}}, i_size} + {{SZ_W{1'b0}}, r_j};
        ij        = {{SZ_W{1'b0}}, r_i} * {{SZ_W{1'b0}}, i_size} + {{SZ_W{1'b0}}, r_j};
        k_last    = (r_k == i_size - SZ_W'(1));
        j_last    = (r_j == i_size - SZ_W'(1));
        i_last    = (r_i == i_size - SZ_W'(1));
        mac_issue = (r_state == ST_MUL);
        out_issue = (r_state == ST_OUT) && (!r_out_valid || pop);
        o_q_pop   = (r_state == ST_IDLE) && !i_q_empty;
        q_pos     = i_q_item.pos[ADDR_W-1:0];
        p_rd_addr = (r_state == ST_OUT) ? {r_bank, r_oidx[ADDR_W-1:0]}
                                        : {r_bank, ik[ADDR_W-1:0]};
        mac_done  = !(r_s1.valid || r_s2.valid || r_s3.valid);
        n_acc     = (r_s3.first ? '0 : r_acc) + r_prod;
        mac_wr    = r_s3.valid && r_s3.last;
    end

    // Product store: element loads and accumulated results share the write port.
    always_ff @(posedge i_clk) begin
        if (o_q_pop && i_q_item.first) begin
            r_pmem[{r_bank, q_pos}] <= i_q_item.element;
        end else if (mac_wr) begin
            r_pmem[{~r_bank, r_s3.dest}] <= n_acc;
        end
        if (out_issue) begin
            r_out_data <= r_pmem[p_rd_addr];
        end else if (mac_issue) begin
            r_pdata <= r_pmem[p_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop && !i_q_item.first) begin
            r_mmem[q_pos] <= i_q_item.element;
        end
        if (mac_issue) begin
            r_mdata <= r_mmem[kj[ADDR_W-1:0]];
        end
    end

    // The 64-bit product modulo 2^64 is built from three partial products of the 32-bit halves.
    always_ff @(posedge i_clk) begin
        r_pp0  <= r_pdata[HALF_W-1:0] * r_mdata[HALF_W-1:0];
        r_pp1  <= HALF_W'(r_pdata[HALF_W-1:0] * r_mdata[ELEM_W-1:HALF_W]);
        r_pp2  <= HALF_W'(r_pdata[ELEM_W-1:HALF_W] * r_mdata[HALF_W-1:0]);
        r_prod <= r_pp0 + {r_pp1 + r_pp2, {HALF_W{1'b0}}};
        if (r_s3.valid) begin
            r_acc <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
            r_s2 <= '0;
            r_s3 <= '0;
        end else begin
            r_s1.valid <= mac_issue;
            r_s1.first <= (r_k == '0);
            r_s1.last  <= k_last;
            r_s1.dest  <= ij[ADDR_W-1:0];
            r_s2       <= r_s1;
            r_s3       <= r_s2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_bank      <= 1'b0;
            r_eoc       <= 1'b0;
            r_i         <= '0;
            r_j         <= '0;
            r_k         <= '0;
            r_oidx      <= '0;
            r_out_valid <= 1'b0;
            r_out_last  <= 1'b0;
        end else begin
            if (out_issue) begin
                r_out_valid <= 1'b1;
                r_out_last  <= (r_oidx == i_cells - CELL_W'(1));
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (o_q_pop) begin
                        r_i    <= '0;
                        r_j    <= '0;
                        r_k    <= '0;
                        r_oidx <= '0;
                        r_eoc  <= i_q_item.eoc;
                        if (i_q_item.eom && !i_q_item.first) begin
                            r_state <= ST_MUL;
                        end else if (i_q_item.eoc) begin
                            r_state <= ST_OUT;
                        end
                    end
                end
                ST_MUL: begin
                    if (k_last) begin
                        r_k <= '0;
                        if (j_last) begin
                            r_j <= '0;
                            r_i <= r_i + SZ_W'(1);
                            if (i_last) begin
                                r_state <= ST_DRAIN;
                            end
                        end else begin
                            r_j <= r_j + SZ_W'(1);
                        end
                    end else begin
                        r_k <= r_k + SZ_W'(1);
                    end
                end
                ST_DRAIN: begin
                    if (mac_done) begin
                        r_bank  <= ~r_bank;
                        r_state <= r_eoc ? ST_OUT : ST_IDLE;
                    end
                end
                ST_OUT: begin
                    if (out_issue) begin
                        r_oidx <= r_oidx + CELL_W'(1);
                        if (r_oidx == i_cells - CELL_W'(1)) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign empty             = !r_out_valid;
    assign o_product_element = r_out_data;
    assign o_last_element    = r_out_last;

endmodule

>>> rtl/matrix_chain_multiplier_core.sv
`timescale 1ns / 1ps
// Top level of the matrix chain multiplier.
// Depends on mcm_pkg, mcm_front, mcm_queue and mcm_back.

// Multiplies a chain of n-by-n matrices of 64-bit unsigned elements, all
// arithmetic wrapping modulo 2^64. Elements are pushed row-major, one matrix
// after another; the first matrix of a chain becomes the running product and
// every later matrix multiplies into it from the right. After the last
// element of the chain, the n*n product elements come out row-major, with
// last_element set on the final one. Register 0 (matrix_size) and register 1
// (chain_length) may only be written while the block is idle; any write to
// them restarts the chain. Size 0 acts as 1 and sizes above MAX_SIZE act as
// MAX_SIZE; chain length 0 acts as 1. The front end tracks the position of
// every element and hands it through a four-entry queue to the back end,
// which stores it while idle. Each matrix after the first is multiplied
// into the running product by one pipelined multiply-accumulate unit, whose
// three-stage multiply pipeline drains before the product banks swap. The
// result is streamed at one transaction per cycle while the consumer keeps
// popping.
module matrix_chain_multiplier_core
    import mcm_pkg::*;
#(
    parameter int unsigned MAX_SIZE = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    input  logic                 push,
    output logic                 full,
    input  logic [ELEM_W-1:0]    i_element,
    output logic                 empty,
    input  logic                 pop,
    output logic [ELEM_W-1:0]    o_product_element,
    output logic                 o_last_element
);

    // Counter widths follow from the largest matrix; the element index keeps
    // at least one bit so that a 1x1 build still has an address.
    localparam int unsigned DEPTH  = MAX_SIZE * MAX_SIZE;
    localparam int unsigned SZ_W   = $clog2(MAX_SIZE + 1);
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CELL_W = ADDR_W + 1;

    logic              q_push;
    t_item             q_in;
    logic              q_full;
    logic              q_pop;
    logic              q_empty;
    t_item             q_out;
    logic [SZ_W-1:0]   size;
    logic [CELL_W-1:0] cells;

    mcm_front #(
        .MAX_SIZE (MAX_SIZE),
        .SZ_W     (SZ_W),
        .ADDR_W   (ADDR_W),
        .CELL_W   (CELL_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .push        (push),
        .i_element   (i_element),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_item    (q_in),
        .o_size      (size),
        .o_cells     (cells)
    );

    // Decouples element intake from the multiply sequencer.
    mcm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_item  (q_out)
    );

    mcm_back #(
        .SZ_W   (SZ_W),
        .ADDR_W (ADDR_W),
        .CELL_W (CELL_W)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_size            (size),
        .i_cells           (cells),
        .i_q_empty         (q_empty),
        .i_q_item          (q_out),
        .o_q_pop           (q_pop),
        .empty             (empty),
        .pop               (pop),
        .o_product_element (o_product_element),
        .o_last_element    (o_last_element)
    );

    // The input side is full exactly when the item queue is full.
    assign full = q_full;

endmodule
